// ===== sv/irc_pkg.sv =====
// shared types, constants and the digit character map for the radix converter
package irc_pkg;

    localparam int VALUE_W   = 64;
    localparam int RADIX_W   = 6;
    localparam int MIN_RADIX = 2;
    localparam int BCD_N     = 20;
    localparam int BCD_W     = 4 * BCD_N;
    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = 6;
    localparam int CNT_W     = 7;
    localparam int DIV_STEPS = 8;
    localparam int DIV_CHUNKS = VALUE_W / DIV_STEPS;

    localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] src_mag;
        logic [RADIX_W-1:0] tgt_mag;
        logic               tgt_neg;
        logic               src_ten;
        logic               is_null;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BCD,
        S_REREAD,
        S_SETUP,
        S_DIV,
        S_PRIME,
        S_EMIT
    } t_state;

    function automatic logic [7:0] f_digit_char(input logic [RADIX_W-1:0] d);
        logic [7:0] c;
        if (d < RADIX_W'(10)) begin
            c = 8'd48 + {2'b00, d};
        end else begin
            c = 8'd55 + {2'b00, d};
        end
        return c;
    endfunction

endpackage

// ===== sv/irc_front.sv =====
// front end: checks radices and sign, builds a job for the queue
module irc_front #(
    parameter int MAX_RADIX = 36
) (
    input  logic signed [63:0] i_value,
    input  logic signed [7:0]  i_source_radix,
    input  logic signed [7:0]  i_target_radix,
    output irc_pkg::t_job      o_job
);
    import irc_pkg::*;

    logic [7:0] w_src;
    logic [7:0] w_tgt;
    logic [7:0] w_src_mag;
    logic [7:0] w_tgt_mag;
    logic       w_src_bad;
    logic       w_tgt_bad;

    always_comb begin
        w_src     = i_source_radix;
        w_tgt     = i_target_radix;
        w_src_mag = w_src[7] ? (~w_src + 8'd1) : w_src;
        w_tgt_mag = w_tgt[7] ? (~w_tgt + 8'd1) : w_tgt;
        w_src_bad = (w_src_mag < 8'(MIN_RADIX)) || (w_src_mag > 8'(MAX_RADIX));
        w_tgt_bad = (w_tgt_mag < 8'(MIN_RADIX)) || (w_tgt_mag > 8'(MAX_RADIX));

        o_job.value   = i_value;
        o_job.src_mag = w_src_mag[RADIX_W-1:0];
        o_job.tgt_mag = w_tgt_mag[RADIX_W-1:0];
        o_job.tgt_neg = w_tgt[7];
        o_job.src_ten = (w_src == 8'd10);
        o_job.is_null = w_src_bad || w_tgt_bad || (w_src[7] && !i_value[63]);
    end

endmodule

// ===== sv/irc_queue.sv =====
// two-entry job queue between front and back
module irc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  irc_pkg::t_job i_job,
    input  logic          i_pop,
    output irc_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import irc_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

// ===== sv/irc_back.sv =====
// back end: decimal reread in the source radix unless it is ten, then digit generation and output
module irc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  irc_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_strobe,
    output logic [7:0]    o_digit_char,
    output logic          o_negative,
    output logic          o_is_null,
    output logic          o_last
);
    import irc_pkg::*;

    t_state             r_state, n_state;
    t_job               r_job, n_job;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [VALUE_W-1:0] r_sum, n_sum;
    logic [VALUE_W-1:0] r_place, n_place;
    logic               r_place_big, n_place_big;
    logic [VALUE_W-1:0] r_num, n_num;
    logic [VALUE_W-1:0] r_t, n_t;
    logic [RADIX_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_strobe, n_strobe;
    logic [7:0]         r_char, n_char;
    logic               r_out_neg, n_out_neg;
    logic               r_out_null, n_out_null;
    logic               r_out_last, n_out_last;

    logic [RADIX_W-1:0] r_buf [BUF_DEPTH];
    logic [RADIX_W-1:0] r_rdata;
    logic               w_buf_we;
    logic [BUF_AW-1:0]  w_buf_raddr;
    logic [CNT_W-1:0]   w_raddr_full;

    logic [BCD_W-1:0]   w_bcd_adj;
    logic [3:0]         w_dig;
    logic               w_dig_bad;
    logic [67:0]        w_dprod;
    logic [68:0]        w_sum_ext;
    logic               w_ovf_add;
    logic [69:0]        w_pprod;
    logic               w_pbig;
    logic               w_dig_ovf;
    logic               w_rest_zero;
    logic [VALUE_W-1:0] w_sum_new;
    logic [VALUE_W-1:0] w_in_mag;
    logic               w_neg_out;
    logic [RADIX_W-1:0] w_div_rem;
    logic [VALUE_W-1:0] w_div_t;
    logic               w_chunk_end;
    logic               w_div_done;

    // double dabble adjust
    always_comb begin
        for (int i = 0; i < BCD_N; i++) begin
            w_bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ?
                                  (r_bcd[4*i +: 4] + 4'd3) : r_bcd[4*i +: 4];
        end
    end

    // one decimal digit of the reread
    assign w_dig       = r_bcd[3:0];
    assign w_dig_bad   = ({2'b00, w_dig} >= r_job.src_mag);
    assign w_dprod     = {64'd0, w_dig} * {4'd0, r_place};
    assign w_sum_ext   = {5'd0, r_sum} + {1'b0, w_dprod};
    assign w_ovf_add   = (w_sum_ext > {5'd0, POS_LIMIT});
    assign w_pprod     = {6'd0, r_place} * {64'd0, r_job.src_mag};
    assign w_pbig      = (w_pprod > {6'd0, POS_LIMIT});
    assign w_dig_ovf   = !w_dig_bad && (w_dig != 4'd0) && (r_place_big || w_ovf_add);
    assign w_rest_zero = (r_bcd[BCD_W-1:4] == '0);
    assign w_sum_new   = w_dig_bad ? '0 : w_sum_ext[VALUE_W-1:0];
    assign w_in_mag    = i_job.value[VALUE_W-1] ? (~i_job.value + 64'd1) : i_job.value;
    assign w_neg_out   = r_job.tgt_neg && r_num[VALUE_W-1];

    // eight restoring division steps per cycle
    always_comb begin
        logic [RADIX_W:0]   v_r;
        logic [RADIX_W-1:0] v_rem;
        logic [VALUE_W-1:0] v_t;
        v_rem = r_rem;
        v_t   = r_t;
        for (int k = 0; k < DIV_STEPS; k++) begin
            v_r = {v_rem, v_t[VALUE_W-1]};
            v_t = {v_t[VALUE_W-2:0], 1'b0};
            if (v_r >= {1'b0, r_job.tgt_mag}) begin
                v_r    = v_r - {1'b0, r_job.tgt_mag};
                v_t[0] = 1'b1;
            end
            v_rem = v_r[RADIX_W-1:0];
        end
        w_div_rem = v_rem;
        w_div_t   = v_t;
    end

    assign w_chunk_end = (r_step == CNT_W'(DIV_CHUNKS - 1));
    assign w_div_done  = w_chunk_end &&
                         ((w_div_t == '0) || (r_cnt == CNT_W'(BUF_DEPTH - 1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty && !i_job.is_null) begin
                    n_state = i_job.src_ten ? S_SETUP : S_BCD;
                end
            end
            S_BCD: begin
                if (r_step == CNT_W'(VALUE_W - 1)) begin
                    n_state = S_REREAD;
                end
            end
            S_REREAD: begin
                if (w_dig_ovf || w_rest_zero) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_PRIME;
                end
            end
            S_PRIME: n_state = S_EMIT;
            S_EMIT: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_job       = r_job;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_sum       = r_sum;
        n_place     = r_place;
        n_place_big = r_place_big;
        n_num       = r_num;
        n_t         = r_t;
        n_rem       = r_rem;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_strobe    = 1'b0;
        n_char      = r_char;
        n_out_neg   = r_out_neg;
        n_out_null  = r_out_null;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_buf_we    = 1'b0;
        w_raddr_full = r_cnt - CNT_W'(1);
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop       = 1'b1;
                    n_job       = i_job;
                    n_bin       = w_in_mag;
                    n_bcd       = '0;
                    n_step      = '0;
                    n_sum       = '0;
                    n_place     = 64'd1;
                    n_place_big = 1'b0;
                    n_num       = i_job.value;
                    if (i_job.is_null) begin
                        n_strobe   = 1'b1;
                        n_char     = 8'd0;
                        n_out_neg  = 1'b0;
                        n_out_null = 1'b1;
                        n_out_last = 1'b1;
                    end
                end
            end
            S_BCD: begin
                n_bcd  = {w_bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_step = r_step + CNT_W'(1);
            end
            S_REREAD: begin
                n_bcd = {4'd0, r_bcd[BCD_W-1:4]};
                if (w_dig_bad) begin
                    n_sum       = '0;
                    n_place     = 64'd1;
                    n_place_big = 1'b0;
                end else begin
                    if (w_dig != 4'd0) begin
                        n_sum = w_sum_ext[VALUE_W-1:0];
                    end
                    if (!r_place_big) begin
                        if (w_pbig) begin
                            n_place_big = 1'b1;
                        end else begin
                            n_place = w_pprod[VALUE_W-1:0];
                        end
                    end
                end
                if (w_dig_ovf) begin
                    n_num = '1;
                end else if (w_rest_zero) begin
                    n_num = (w_dig != 4'd0 || w_dig_bad) ? w_sum_new : r_sum;
                    if (r_job.value[VALUE_W-1]) begin
                        n_num = ~n_num + 64'd1;
                    end
                end
            end
            S_SETUP: begin
                n_neg  = w_neg_out;
                n_t    = w_neg_out ? (~r_num + 64'd1) : r_num;
                n_rem  = '0;
                n_step = '0;
                n_cnt  = '0;
            end
            S_DIV: begin
                n_t    = w_div_t;
                n_rem  = w_div_rem;
                n_step = r_step + CNT_W'(1);
                if (w_chunk_end) begin
                    w_buf_we = 1'b1;
                    n_rem    = '0;
                    n_step   = '0;
                    n_cnt    = r_cnt + CNT_W'(1);
                end
            end
            S_PRIME: begin
                w_raddr_full = r_cnt - CNT_W'(1);
            end
            S_EMIT: begin
                n_strobe     = 1'b1;
                n_char       = f_digit_char(r_rdata);
                n_out_neg    = r_neg;
                n_out_null   = 1'b0;
                n_out_last   = (r_cnt == CNT_W'(1));
                n_cnt        = r_cnt - CNT_W'(1);
                w_raddr_full = r_cnt - CNT_W'(2);
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    assign w_buf_raddr = w_raddr_full[BUF_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf[r_cnt[BUF_AW-1:0]] <= w_div_rem;
        end
        r_rdata <= r_buf[w_buf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_bin       <= n_bin;
        r_bcd       <= n_bcd;
        r_sum       <= n_sum;
        r_place     <= n_place;
        r_place_big <= n_place_big;
        r_num       <= n_num;
        r_t         <= n_t;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_cnt       <= n_cnt;
        r_neg       <= n_neg;
        r_char      <= n_char;
        r_out_neg   <= n_out_neg;
        r_out_null  <= n_out_null;
        r_out_last  <= n_out_last;
    end

    assign o_strobe     = r_strobe;
    assign o_digit_char = r_char;
    assign o_negative   = r_out_neg;
    assign o_is_null    = r_out_null;
    assign o_last       = r_out_last;

endmodule

// ===== sv/integer_radix_conversion.sv =====
// top level of the integer radix converter
// An item is taken when start is high and busy is low; busy rises only when the
// two-entry job queue is full. Results come one per cycle on o_strobe and cannot
// be held off. A null item gives its single result on the cycle after it
// reaches the back end. Otherwise the back end converts the magnitude from binary to
// decimal by double dabble (skipped when the source radix is ten), rereads the
// decimal digits in the source radix one per cycle (up to 19), then forms the output
// digits least significant first in the restoring divider, then streams them out
// one digit per cycle, most significant first.
module integer_radix_conversion #(
    parameter int MAX_RADIX = 36
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [63:0] i_value,
    input  logic signed [7:0]  i_source_radix,
    input  logic signed [7:0]  i_target_radix,
    output logic              o_strobe,
    output logic [7:0]        o_digit_char,
    output logic              o_negative,
    output logic              o_is_null,
    output logic              o_last
);
    import irc_pkg::*;

    t_job w_front_job;
    t_job w_head_job;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;

    assign w_push = start && !w_full;
    assign busy   = w_full;

    irc_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .i_value        (i_value),
        .i_source_radix (i_source_radix),
        .i_target_radix (i_target_radix),
        .o_job          (w_front_job)
    );

    irc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    irc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_head_job),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_negative   (o_negative),
        .o_is_null    (o_is_null),
        .o_last       (o_last)
    );

endmodule

// ===== sv/irc_checker.sv =====
// port-level checks for the radix converter and their binding
module irc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic [7:0] o_digit_char,
    input logic       o_negative,
    input logic       o_is_null,
    input logic       o_last
);

    a_null_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_null |-> o_last && (o_digit_char == 8'd0) && !o_negative)
        else $error("null item malformed");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_null |->
        ((o_digit_char >= 8'd48) && (o_digit_char <= 8'd57)) ||
        ((o_digit_char >= 8'd65) && (o_digit_char <= 8'd90)))
        else $error("digit character out of range");

    a_digits_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && !o_is_null && (o_negative == $past(o_negative)))
        else $error("digit run broken or sign changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("outputs active after reset");

endmodule

bind integer_radix_conversion irc_checker u_irc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_digit_char (o_digit_char),
    .o_negative   (o_negative),
    .o_is_null    (o_is_null),
    .o_last       (o_last)
);

// ===== bench/integer_radix_conversion_test.sv =====
// self-checking testbench for the integer radix converter
module integer_radix_conversion_test;

    localparam int LOW_RADIX  = 2;
    localparam int HIGH_RADIX = 36;

    typedef struct {
        logic [7:0] digit_char;
        logic       negative;
        logic       is_null;
        logic       last;
    } t_digit;

    int error_count = 0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    // rereads the decimal digits of a magnitude in radix base; 0 on overflow
    function automatic bit reread_digits(input logic [63:0] mag_in, input int base,
                                         output logic [63:0] sum_out);
        logic [127:0] sum;
        logic [127:0] place;
        logic [63:0]  rest;
        logic [63:0]  d;
        sum = 0;
        place = 1;
        rest = mag_in;
        sum_out = 0;
        do begin
            d = rest % 10;
            if (d >= base) begin
                sum = 0;
                place = 1;
            end else begin
                if (d != 0) begin
                    sum = sum + d * place;
                    if (sum > 128'h7FFF_FFFF_FFFF_FFFF) return 0;
                end
                if (place <= 128'h7FFF_FFFF_FFFF_FFFF) place = place * base;
            end
            rest = rest / 10;
        end while (rest > 0);
        sum_out = sum[63:0];
        return 1;
    endfunction

    class digit_scoreboard;
        t_digit pending[$];

        function void note_item(input logic [63:0] value, input int sr, input int tr);
            int sm, tm, n;
            bit v_neg, neg_out;
            logic [63:0] num, m, s, t;
            logic [7:0] chars[64];
            t_digit r;
            sm = sr < 0 ? -sr : sr;
            tm = tr < 0 ? -tr : tr;
            v_neg = value[63];
            if (sm < LOW_RADIX || sm > HIGH_RADIX || tm < LOW_RADIX || tm > HIGH_RADIX ||
                (sr < 0 && !v_neg)) begin
                r = '{8'd0, 1'b0, 1'b1, 1'b1};
                pending.push_back(r);
                return;
            end
            num = value;
            if (sr != 10) begin
                m = v_neg ? -value : value;
                if (reread_digits(m, sm, s)) num = v_neg ? -s : s;
                else num = '1;
            end
            neg_out = (tr < 0) && num[63];
            t = neg_out ? -num : num;
            n = 0;
            do begin
                chars[n] = (t % tm) < 10 ? 8'd48 + 8'(t % tm) : 8'd55 + 8'(t % tm);
                t = t / tm;
                n++;
            end while (t > 0 && n < 64);
            for (int k = 0; k < n; k++) begin
                r = '{chars[n-1-k], neg_out, 1'b0, k == n - 1};
                pending.push_back(r);
            end
        endfunction

        task check_digit(input t_digit got);
            t_digit exp_d;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result char=%h", got.digit_char));
                return;
            end
            exp_d = pending.pop_front();
            if (got.digit_char !== exp_d.digit_char || got.negative !== exp_d.negative ||
                got.is_null !== exp_d.is_null || got.last !== exp_d.last)
                report($sformatf("got c=%h n=%b z=%b l=%b exp c=%h n=%b z=%b l=%b",
                    got.digit_char, got.negative, got.is_null, got.last,
                    exp_d.digit_char, exp_d.negative, exp_d.is_null, exp_d.last));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic signed [63:0] i_value = 0;
    logic signed [7:0]  i_source_radix = 0;
    logic signed [7:0]  i_target_radix = 0;
    logic        o_strobe;
    logic [7:0]  o_digit_char;
    logic        o_negative, o_is_null, o_last;

    digit_scoreboard sb = new();
    bit steady = 0;
    int item_count = 0;
    int result_count = 0;

    integer_radix_conversion u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_value(i_value), .i_source_radix(i_source_radix),
        .i_target_radix(i_target_radix), .o_strobe(o_strobe),
        .o_digit_char(o_digit_char), .o_negative(o_negative),
        .o_is_null(o_is_null), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_digit('{o_digit_char, o_negative, o_is_null, o_last});
            result_count++;
        end
    end

    task automatic send_item(input logic [63:0] v, input logic [7:0] sr, input logic [7:0] tr);
        while (!steady && $urandom_range(99) < 35) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_value <= v;
        i_source_radix <= sr;
        i_target_radix <= tr;
        do @(posedge i_clk); while (busy);
        sb.note_item(v, $signed(sr), $signed(tr));
        item_count++;
    endtask

    function automatic logic [7:0] pick_radix();
        int sel;
        logic [7:0] r;
        sel = $urandom_range(99);
        if (sel < 8) r = 8'($urandom);
        else if (sel < 14) r = 8'($urandom_range(1, 0));
        else r = 8'($urandom_range(HIGH_RADIX, LOW_RADIX));
        if ($urandom_range(2) == 0) r = -r;
        return r;
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int sel;
        sel = $urandom_range(5);
        case (sel)
            0: v = {$urandom, $urandom};
            1: v = $urandom_range(999999);
            2: v = {32'd0, $urandom};
            default: begin
                v = 0;
                repeat ($urandom_range(19, 1)) v = v * 10 + $urandom_range(9);
            end
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    initial begin
        logic [63:0] v;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 8'sd10, 8'sd2);
        send_item(64'h8000_0000_0000_0000, 8'sd10, -8'sd2);
        send_item(64'h8000_0000_0000_0000, 8'sd10, 8'sd36);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 8'sd10, 8'sd2);
        send_item(-64'sd1, 8'sd10, -8'sd10);
        send_item(64'd0, 8'sd10, 8'sd10);
        send_item(64'd0, 8'sd2, -8'sd36);
        send_item(64'd1, 8'sd1, 8'sd10);
        send_item(64'd1, 8'sd37, 8'sd10);
        send_item(64'd1, 8'sd10, 8'sd37);
        send_item(64'd1, 8'sd10, -8'sd1);
        send_item(64'd1, -8'sd128, 8'sd127);
        send_item(64'd1, 8'sd127, -8'sd128);
        send_item(64'd123, -8'sd8, 8'sd10);
        send_item(-64'sd123, -8'sd8, 8'sd10);
        send_item(64'd1291, 8'sd8, 8'sd16);
        send_item(64'd1111111111111111111, 8'sd2, 8'sd10);
        send_item(64'd9999999999999999999 >> 1, 8'sd36, 8'sd10);
        send_item(64'd8000000000000000000, 8'sd36, -8'sd10);
        send_item(-64'sd1000000000000000000, 8'sd36, -8'sd2);
        send_item(64'd100000000000000000, 8'sd36, 8'sd10);
        send_item(-64'sd35, 8'sd36, -8'sd36);
        send_item(64'd1234567890, 8'sd16, -8'sd16);
        for (int i = 0; i < 150; i++) begin
            steady = (i >= 60 && i < 90);
            v = pick_value();
            send_item(v, pick_radix(), pick_radix());
        end
        start <= 0;
        steady = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d items and %0d result digits", item_count, result_count);
        $display("null, radix, overflow, and extreme value cases included");
        if (error_count == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
